// ===== hdl/crc32_msb_first_byte_stream_core_assert.svh =====
// Assertion macros used by the CRC core top level.
`ifndef CRC32_MSB_FIRST_BYTE_STREAM_CORE_ASSERT_SVH
`define CRC32_MSB_FIRST_BYTE_STREAM_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CRC32M_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("crc32m assertion failed");

// Next-cycle implication, checked outside reset.
`define CRC32M_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("crc32m assertion failed");

`endif

// ===== hdl/crc32m_pkg.sv =====
// Types and constants of the CRC core.
package crc32m_pkg;

    localparam int CRC_W  = 32;
    localparam int BYTE_W = 8;

    typedef logic [CRC_W-1:0]  crc_t;
    typedef logic [BYTE_W-1:0] byte_t;

    localparam crc_t POLY_RESET = 32'h04C1_1DB7;
    localparam crc_t CRC_ZERO   = '0;

    // Register indexes on the configuration port.
    localparam logic REG_POLYNOMIAL = 1'b0;

    typedef struct packed {
        logic valid;
        logic free;
    } out_status_t;

endpackage

// ===== hdl/crc32m_step.sv =====
// One-byte MSB-first CRC update, eight shift-xor steps.
module crc32m_step (
    input  crc32m_pkg::crc_t  crc_in,
    input  crc32m_pkg::byte_t data_in,
    input  crc32m_pkg::crc_t  poly,
    output crc32m_pkg::crc_t  crc_out
);

    always_comb begin
        crc32m_pkg::crc_t acc;
        logic             top;
        acc = crc_in ^ {data_in, {(crc32m_pkg::CRC_W - crc32m_pkg::BYTE_W){1'b0}}};
        for (int k = 0; k < crc32m_pkg::BYTE_W; k++) begin
            top = acc[crc32m_pkg::CRC_W-1];
            acc = {acc[crc32m_pkg::CRC_W-2:0], 1'b0};
            if (top) begin
                acc = acc ^ poly;
            end
        end
        crc_out = acc;
    end

endmodule

// ===== hdl/crc32m_out_reg.sv =====
// Result register driving the output channel.
module crc32m_out_reg (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    load,
    input  crc32m_pkg::crc_t        crc_in,
    input  logic                    m_ready,
    output crc32m_pkg::crc_t        m_crc_value,
    output crc32m_pkg::out_status_t status
);

    logic             valid_reg;
    logic             valid_next;
    crc32m_pkg::crc_t crc_reg;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && m_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload: load only, no reset needed.
    always_ff @(posedge aclk) begin
        if (load) begin
            crc_reg <= crc_in;
        end
    end

    assign m_crc_value  = crc_reg;
    assign status.valid = valid_reg;
    assign status.free  = !valid_reg || m_ready;

endmodule

// ===== hdl/crc32_msb_first_byte_stream_core.sv =====
// Top level of the MSB-first byte-stream CRC-32 core.
//
// Usage:
//   Input channel s_valid/s_ready carries one message byte per item
//   (s_data_byte) with s_last_byte marking the final byte of a message.
//   Output channel m_valid/m_ready carries one item per message: the
//   32-bit CRC (m_crc_value), non-reflected, zero seed, no final XOR.
//   The polynomial sits at byte address 0 of the APB port (reset value
//   0x04C11DB7); write it only while the core is idle.
// Timing:
//   An accepted byte lands in the input register, and from there it is
//   absorbed into the running CRC by eight unrolled shift-xor steps. The
//   CRC of a message passes through the result register to m_valid. One
//   byte per cycle is sustained unless a last byte waits on a full result
//   slot; the byte update loop on the running CRC register sets that rate.
// Reset (aresetn low, synchronous): running CRC clears to zero, both
//   valid flags drop, polynomial returns to its reset value.
// Stall: while a result waits, bytes not marked last keep flowing; a last
//   byte waits in the input register until the result register frees up,
//   and s_ready drops behind it.
module crc32_msb_first_byte_stream_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_last_byte,
    // Output channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_crc_value,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "crc32_msb_first_byte_stream_core_assert.svh"

    // Configuration register
    crc32m_pkg::crc_t poly_reg;
    logic             cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == crc32m_pkg::REG_POLYNOMIAL);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            poly_reg <= crc32m_pkg::POLY_RESET;
        end else if (cfg_write) begin
            poly_reg <= pwdata;
        end
    end

    assign prdata = (paddr[2] == crc32m_pkg::REG_POLYNOMIAL) ? poly_reg
                                                             : crc32m_pkg::CRC_ZERO;

    // Input register
    logic                    in_valid_reg;
    logic                    in_valid_next;
    crc32m_pkg::byte_t       in_byte_reg;
    logic                    in_last_reg;
    logic                    accept;
    logic                    fire;
    crc32m_pkg::out_status_t out_status;

    // Advance a held item unless it is a last byte facing a full result slot.
    assign fire    = in_valid_reg && (!in_last_reg || out_status.free);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (fire) begin
            in_valid_next = 1'b0;
        end
        if (accept) begin
            in_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            in_byte_reg <= s_data_byte;
            in_last_reg <= s_last_byte;
        end
    end

    // Running CRC
    crc32m_pkg::crc_t crc_reg;
    crc32m_pkg::crc_t crc_next;
    crc32m_pkg::crc_t crc_step;

    crc32m_step u_step (
        .crc_in  (crc_reg),
        .data_in (in_byte_reg),
        .poly    (poly_reg),
        .crc_out (crc_step)
    );

    // Drop back to zero after the last byte of a message.
    always_comb begin
        crc_next = crc_reg;
        if (fire) begin
            crc_next = in_last_reg ? crc32m_pkg::CRC_ZERO : crc_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= crc32m_pkg::CRC_ZERO;
        end else begin
            crc_reg <= crc_next;
        end
    end

    // Result register
    crc32m_out_reg u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load        (fire && in_last_reg),
        .crc_in      (crc_step),
        .m_ready     (m_ready),
        .m_crc_value (m_crc_value),
        .status      (out_status)
    );

    assign m_valid = out_status.valid;

    // Checks
    `CRC32M_ASSERT_NEXT(a_clear_after_last, aclk, aresetn,
        fire && in_last_reg, crc_reg == crc32m_pkg::CRC_ZERO)
    `CRC32M_ASSERT_NEXT(a_result_value, aclk, aresetn,
        fire && in_last_reg, m_valid && (m_crc_value == $past(crc_step)))
    `CRC32M_ASSERT_NEXT(a_hold_stalled_item, aclk, aresetn,
        in_valid_reg && !fire, in_valid_reg && $stable(in_byte_reg) && $stable(in_last_reg))

endmodule
